// File: design/swnp_pkg.sv
// Shared types and constants for the sweep window neighbor pair block.
package swnp_pkg;

  localparam int WINDOW_DEPTH = 32;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int COORD_W      = 16;

  // configuration register indexes
  localparam logic CFG_ROW_DISTANCE    = 1'b0;
  localparam logic CFG_COLUMN_DISTANCE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // one window entry, id in the low bits
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] id;
  } entry_t;

endpackage

// File: design/sweep_window_neighbor_pairs.sv
// Top level of the sweep window neighbor pair block.
//
// Usage: map nodes enter on the in_ stream (in_tdata = node_id, node_y,
// node_x; in_tuser = start_list) in list order. Each node is compared
// against the live entries of a 32-deep window of earlier nodes, oldest
// first. An entry whose |dy| exceeds row_distance is retired for good; one
// with |dx| below column_distance yields a pair on the out_ stream. The
// last pair of a node carries tlast; tuser flags that storing this node
// drops a still-live window entry. Nodes without matches give no transfer.
// row_distance and column_distance are written on the cfg_ port (index 0
// and 1); the user must write them only while the block is idle, which the
// block itself does not enforce. cfg_ready is always high. A new node is
// taken only while idle: after the window reads through the single read
// port, the compare of the last entry, a step that sees the scan end, and
// the write-back; a stalling receiver holds this up. A pair is held until
// it is known whether it is the last one: it enters the output register
// when the next match is compared, or with the write-back.
// A stalled receiver freezes the scan once a second pair is ready; nothing
// is dropped. Reset empties the window and clears both distances; window
// memory contents are not cleared, only the live flags.
module sweep_window_neighbor_pairs (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // node_id[15:0], node_y[31:16], node_x[47:32]
  input  logic        in_tuser,   // start_list
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // earlier_id[15:0], earlier_y[31:16], earlier_x[47:32],
  // later_id[63:48], later_y[79:64], later_x[95:80]
  output logic [95:0] out_tdata,
  output logic        out_tlast,  // last_pair
  output logic        out_tuser,  // window_overflowed
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  swnp_pkg::state_t state_r, state_nxt;

  // window storage: payload in memory, live flags in flops
  swnp_pkg::entry_t                      mem [swnp_pkg::WINDOW_DEPTH];
  logic [swnp_pkg::WINDOW_DEPTH-1:0]     live_r;
  logic [swnp_pkg::ADDR_W-1:0]           base_r;     // oldest slot

  // current node
  swnp_pkg::entry_t                      node_r;

  // scan pipeline: read issue, then compare
  logic [swnp_pkg::CNT_W-1:0]            ri_r;
  logic                                  cv_r;
  logic                                  cfirst_r;
  logic [swnp_pkg::ADDR_W-1:0]           cs_r;
  swnp_pkg::entry_t                      rd_r;

  // held pair awaiting the next match or the end of scan
  logic                                  pend_v_r;
  swnp_pkg::entry_t                      pend_r;
  logic                                  ovf_r;

  // output register
  logic                                  out_v_r;
  logic [95:0]                           out_data_r;
  logic                                  out_last_r;
  logic                                  out_ovf_r;

  logic [15:0]                           row_dist_r;
  logic [15:0]                           col_dist_r;

  logic                                  accept;
  logic                                  out_free;
  logic                                  cmp_live;
  logic signed [16:0]                    dy, dx;
  logic [16:0]                           ady, adx;
  logic                                  kill, hit, push_mid, adv;
  logic                                  rd_en, scan_done, flush_go, out_load;
  logic [swnp_pkg::ADDR_W-1:0]           rd_addr;

  assign in_tready  = (state_r == swnp_pkg::ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  assign out_free = !out_v_r || out_tready;

  // compare stage: 17-bit differences cannot wrap
  assign cmp_live = live_r[cs_r];
  assign dy  = $signed({node_r.y[15], node_r.y}) - $signed({rd_r.y[15], rd_r.y});
  assign dx  = $signed({node_r.x[15], node_r.x}) - $signed({rd_r.x[15], rd_r.x});
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign kill = cv_r && cmp_live && (ady > {1'b0, row_dist_r});
  assign hit  = cv_r && cmp_live && !kill && (adx < {1'b0, col_dist_r});

  // a second match pushes the held pair out; stall if the output is busy
  assign push_mid = hit && pend_v_r;
  assign adv      = !(push_mid && !out_free);

  assign rd_addr   = base_r + ri_r[swnp_pkg::ADDR_W-1:0];
  assign rd_en     = (state_r == swnp_pkg::ST_SCAN) && adv &&
                     (ri_r < swnp_pkg::CNT_W'(swnp_pkg::WINDOW_DEPTH));
  assign scan_done = (ri_r == swnp_pkg::CNT_W'(swnp_pkg::WINDOW_DEPTH)) && !cv_r;
  assign flush_go  = (state_r == swnp_pkg::ST_FLUSH) && (!pend_v_r || out_free);
  assign out_load  = ((state_r == swnp_pkg::ST_SCAN) && push_mid && out_free) ||
                     (flush_go && pend_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swnp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swnp_pkg::ST_IDLE: begin
        if (accept) state_nxt = swnp_pkg::ST_SCAN;
      end
      swnp_pkg::ST_SCAN: begin
        if (scan_done) state_nxt = swnp_pkg::ST_FLUSH;
      end
      swnp_pkg::ST_FLUSH: begin
        if (flush_go) state_nxt = swnp_pkg::ST_IDLE;
      end
      default: state_nxt = swnp_pkg::ST_IDLE;
    endcase
  end

  // window memory: one read port, written back after the scan
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
    if (flush_go) begin
      mem[base_r] <= node_r;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_dist_r <= '0;
      col_dist_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swnp_pkg::CFG_ROW_DISTANCE:    row_dist_r <= cfg_data;
        swnp_pkg::CFG_COLUMN_DISTANCE: col_dist_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan control, live flags, held pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r   <= '0;
      base_r   <= '0;
      ri_r     <= '0;
      cv_r     <= 1'b0;
      cfirst_r <= 1'b0;
      pend_v_r <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      if (accept) begin
        node_r   <= in_tdata;
        ri_r     <= '0;
        cv_r     <= 1'b0;
        pend_v_r <= 1'b0;
        ovf_r    <= 1'b0;
        if (in_tuser) begin
          live_r <= '0;
          base_r <= '0;
        end
      end
      if ((state_r == swnp_pkg::ST_SCAN) && adv) begin
        if (rd_en) begin
          ri_r     <= ri_r + 1'b1;
          cv_r     <= 1'b1;
          cs_r     <= rd_addr;
          cfirst_r <= (ri_r == '0);
        end else begin
          cv_r <= 1'b0;
        end
        if (kill) live_r[cs_r] <= 1'b0;
        // oldest slot is compared first: its fate decides the overflow flag
        if (cv_r && cfirst_r) ovf_r <= cmp_live && !kill;
        if (hit) begin
          pend_r   <= rd_r;
          pend_v_r <= 1'b1;
        end
      end
      if (flush_go) begin
        live_r[base_r] <= 1'b1;
        base_r         <= base_r + 1'b1;
        pend_v_r       <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {node_r, pend_r};
      out_last_r <= (state_r == swnp_pkg::ST_FLUSH);
      out_ovf_r  <= ovf_r;
    end
  end

endmodule
